// ===== src/npp_pkg.sv =====
// Shared constants and types for the normal-CDF position predictor.
package npp_pkg;

    localparam int KEY_BITS      = 48;
    localparam int PHI_FRAC_BITS = 24;

    localparam int KEY_W   = 48;
    localparam int MEAN_W  = 56;
    localparam int INV_W   = 48;
    localparam int SCALE_W = 32;
    localparam int POS_W   = 40;
    localparam int CFG_W   = 56;
    localparam int ADDR_W  = 2;

    localparam int Q_BITS  = 24;
    localparam int Z_W     = 22;
    localparam int C_W     = 27;
    localparam int E_W     = 49;
    localparam int PROD_W  = 104;
    localparam int SQ_W    = 98;

    localparam int PHI_W     = PHI_FRAC_BITS + 1;
    localparam int DIV_STEPS = PHI_W;
    localparam int DIV_W     = 49;
    localparam int POS_SHIFT = PHI_FRAC_BITS - 8;

    localparam logic [ADDR_W-1:0] REG_MEAN  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_INV   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_SCALE = 2'd2;

    localparam logic [C_W-1:0]   C_Q32    = 27'd111032287;
    localparam logic [Z_W-1:0]   Z_CLAMP  = 22'd2097152;
    localparam logic [E_W-1:0]   ONE_Q24  = E_W'(1) << Q_BITS;
    localparam logic [E_W-1:0]   E_SAT    = E_W'(1) << 48;
    localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(1) << 23;

    typedef logic [E_W-1:0]   e_t;
    typedef logic [PHI_W-1:0] phi_t;

endpackage

// ===== src/npp_square.sv =====
// One saturating Q25.24 squaring, split over two register stages.
module npp_square
    import npp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  e_t   in_e,
    output logic out_valid,
    output e_t   out_e
);

    logic        va_reg;
    logic        vb_reg;
    logic [49:0] p11_reg;
    logic [48:0] p10_reg;
    logic [47:0] p00_reg;
    e_t          e_reg;
    logic [SQ_W-1:0] sq;
    e_t          e_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_comb
    begin
        sq = (SQ_W'(p11_reg) << 48) + (SQ_W'(p10_reg) << 25) + SQ_W'(p00_reg);
        if (sq[SQ_W-1:72] != '0)
            e_next = E_SAT;
        else
            e_next = E_W'(sq[71:24]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p11_reg <= 50'(in_e[48:24]) * 50'(in_e[48:24]);
            p10_reg <= 49'(in_e[48:24]) * 49'(in_e[23:0]);
            p00_reg <= 48'(in_e[23:0]) * 48'(in_e[23:0]);
            e_reg   <= e_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_e     = e_reg;

endmodule

// ===== src/npp_div.sv =====
// Pipelined restoring divider: phi = 2^(24+F) / (2^24 + e), one quotient bit per stage.
module npp_div
    import npp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  e_t   in_e,
    output logic out_valid,
    output phi_t out_phi
);

    logic [DIV_STEPS:0] v_reg;
    logic [DIV_W-1:0]   d_reg [0:DIV_STEPS-1];
    logic [DIV_W-1:0]   r_reg [0:DIV_STEPS-1];
    phi_t               q_reg [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= DIV_W'(ONE_Q24) + DIV_W'(in_e);
            r_reg[0] <= DIV_INIT;
            q_reg[0] <= '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++)
        begin : g_step
            logic [DIV_W:0] rs;
            logic           ge;

            always_comb
            begin
                rs = {r_reg[g], 1'b0};
                ge = (rs >= {1'b0, d_reg[g]});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    q_reg[g+1] <= {q_reg[g][PHI_W-2:0], ge};
            end

            if (g < DIV_STEPS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        d_reg[g+1] <= d_reg[g];
                        r_reg[g+1] <= ge ? DIV_W'(rs - {1'b0, d_reg[g]})
                                         : rs[DIV_W-1:0];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[DIV_STEPS];
    assign out_phi   = q_reg[DIV_STEPS];

endmodule

// ===== src/normal_cdf_position_predict_top.sv =====
// Top level of the normal-CDF position predictor.
// Usage:
//   Keys enter on the s_ stream (tdata = key) and predicted positions leave
//   on the m_ stream (tdata = position, unsigned Q32.8). Each key gives
//   exactly one position, in order.
//   Registers mean_q8, inv_stdev and scale are written through cfg_we,
//   cfg_addr and cfg_wdata while no transaction is in flight.
//   Throughput: one key per cycle while m_tready does not hold the pipeline;
//   the pipeline holds one item per stage (input subtract, split 56x48
//   product, z clamp, t product, base, six two-stage squarings, 26-stage
//   divider, scale product, output register).
//   Reset clears all valid bits and loads mean 0, inv_stdev 1.0, scale 0.
//   When m_tready is low while a position waits, the whole pipeline holds
//   and s_tready drops; nothing is lost or repeated.
module normal_cdf_position_predict_top
    import npp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [KEY_W-1:0]    s_tdata,    // [47:0] key
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [POS_W-1:0]    m_tdata,    // [39:0] position
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    logic [MEAN_W-1:0]  mean_reg;
    logic [INV_W-1:0]   inv_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic en;

    logic [KEY_W-1:0]  key_m;
    logic [MEAN_W-1:0] kq;
    logic [MEAN_W:0]   diff;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [MEAN_W-1:0] dmag_reg;
    logic              neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [51:0]       p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PROD_W-1:0] prod;
    logic [Z_W-1:0]    zmag_reg;
    logic [Z_W+C_W-1:0] tprod_reg;
    logic [24:0]       t;
    e_t                base_reg;

    logic [6:0] sv;
    e_t         se [0:6];

    logic       dv;
    phi_t       phi;

    logic                     v6_reg;
    logic [SCALE_W+PHI_W-1:0] pprod_reg;
    logic                     out_v_reg;
    logic [POS_W-1:0]         pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            inv_reg   <= INV_W'(64'h1_0000_0000);
            scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MEAN:  mean_reg  <= cfg_wdata[MEAN_W-1:0];
                REG_INV:   inv_reg   <= cfg_wdata[INV_W-1:0];
                REG_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        key_m = KEY_W'(s_tdata[KEY_BITS-1:0]);
        kq    = {key_m, 8'd0};
        diff  = {1'b0, kq} - {1'b0, mean_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= dv;
            out_v_reg <= v6_reg;
        end
    end

    always_comb
    begin
        prod = PROD_W'(p00_reg) + (PROD_W'(p01_reg) << 24)
             + (PROD_W'(p10_reg) << 28) + (PROD_W'(p11_reg) << 52);
        t    = tprod_reg[Z_W+C_W-1:24];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= diff[MEAN_W];
            dmag_reg <= diff[MEAN_W] ? (mean_reg - kq) : diff[MEAN_W-1:0];

            neg2_reg <= neg1_reg;
            p00_reg  <= 52'(dmag_reg[27:0])  * 52'(inv_reg[23:0]);
            p01_reg  <= 52'(dmag_reg[27:0])  * 52'(inv_reg[47:24]);
            p10_reg  <= 52'(dmag_reg[55:28]) * 52'(inv_reg[23:0]);
            p11_reg  <= 52'(dmag_reg[55:28]) * 52'(inv_reg[47:24]);

            neg3_reg <= neg2_reg;
            if (prod[PROD_W-1:45] != '0)
                zmag_reg <= Z_CLAMP;
            else
                zmag_reg <= Z_W'(prod[44:24]);

            neg4_reg  <= neg3_reg;
            tprod_reg <= (Z_W+C_W)'(zmag_reg) * (Z_W+C_W)'(C_Q32);

            base_reg <= neg4_reg ? (ONE_Q24 + E_W'(t)) : (ONE_Q24 - E_W'(t));

            pprod_reg <= (SCALE_W+PHI_W)'(scale_reg) * (SCALE_W+PHI_W)'(phi);
            pos_reg   <= pprod_reg[POS_SHIFT+POS_W-1:POS_SHIFT];
        end
    end

    assign sv[0] = v5_reg;
    assign se[0] = base_reg;

    genvar g;
    generate
        for (g = 0; g < 6; g++)
        begin : g_sq
            npp_square u_square (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (sv[g]),
                .in_e      (se[g]),
                .out_valid (sv[g+1]),
                .out_e     (se[g+1])
            );
        end
    endgenerate

    npp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv[6]),
        .in_e      (se[6]),
        .out_valid (dv),
        .out_phi   (phi)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = pos_reg;

endmodule
